// ===== rtl/greedy_word_wrap_macros.svh =====
// Assertion macros shared by the word-wrap RTL.
`ifndef GREEDY_WORD_WRAP_MACROS_SVH
`define GREEDY_WORD_WRAP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GWW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("word wrap: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define GWW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("word wrap: next-cycle check failed");

`endif

// ===== rtl/gww_pkg.sv =====
// Package: types, constants and codes of the greedy word-wrap block.
package gww_pkg;

    localparam int LINE_W   = 10;
    localparam int CHAR_W   = 8;
    localparam int SUM_W    = LINE_W + 1;
    localparam int MAX_WORD_DEF = 32;

    localparam logic [LINE_W-1:0] LINE_WIDTH_RST = 10'd75;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT,
        S_NL,
        S_SP,
        S_ADD,
        S_WORD,
        S_END_NL
    } t_state;

    typedef struct packed {
        logic [LINE_W-1:0] a;
        logic [LINE_W-1:0] b;
        logic              cin;
        logic [LINE_W-1:0] limit;
    } t_alu_req;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             gt;
    } t_alu_rsp;

endpackage

// ===== rtl/gww_alu.sv =====
// Shared adder and limit comparator used by the wrap sequencer.
module gww_alu (
    input  gww_pkg::t_alu_req i_req,
    output gww_pkg::t_alu_rsp o_rsp
);
    import gww_pkg::*;

    logic [SUM_W-1:0] sum;

    always_comb begin
        sum = {1'b0, i_req.a} + {1'b0, i_req.b} + {{(SUM_W-1){1'b0}}, i_req.cin};
        o_rsp.sum = sum;
        o_rsp.gt  = sum > {1'b0, i_req.limit};
    end

endmodule

// ===== rtl/greedy_word_wrap.sv =====
// Greedy word-wrap line filler: top level with sequencer and word buffer.
//
// Input stream: one item per text byte. tdata carries the byte, tuser is the
// command (0 = text byte, 1 = end of text). Output stream: one item per output
// byte, tdata is the byte, tlast marks the last result of an input item and
// tuser flags word bytes of a word that lost bytes to capacity.
// The configuration port writes line_width (reset value 75) on i_cfg_we;
// write it only while the block is idle.
// A word byte is taken with no results. A separator or end of text that
// completes a word of L bytes keeps the block busy for a fit check on the
// shared adder, an optional newline or space, a line-length update on the
// shared adder, then the L word bytes read from the word buffer. End of text
// adds a closing newline when the line is not empty. The input is not ready
// while a word is being emitted.
// Results go through one output register; when the receiver stalls the
// sequencer holds in its current emission step until the register frees.
// Reset clears the line length, word length, overflow flag and output valid;
// the word buffer holds no reset value and is only read below the word length.
`include "greedy_word_wrap_macros.svh"

module greedy_word_wrap #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [gww_pkg::LINE_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [gww_pkg::CHAR_W-1:0]  i_s_axis_tdata,  // [7:0] char_in
    input  logic                        i_s_axis_tuser,  // [0] cmd
    // output stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [gww_pkg::CHAR_W-1:0]  o_m_axis_tdata,  // [7:0] char_out
    output logic                        o_m_axis_tlast,
    output logic                        o_m_axis_tuser   // [0] word_overflow
);
    import gww_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    t_state             r_state, n_state;
    logic [LINE_W-1:0]  r_width;
    logic [LINE_W-1:0]  r_ll, n_ll;
    logic [LEN_W-1:0]   r_wl, n_wl;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic               r_ovf, n_ovf;
    logic               r_end;
    logic [CHAR_W-1:0]  r_rd_data;
    logic [CHAR_W-1:0]  r_mem [MAX_WORD];

    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_data;
    logic               r_out_last;
    logic               r_out_ovf;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    logic               acc;
    logic               is_sep;
    logic               is_end;
    logic               emit_ok;
    logic               last_byte;
    logic               em_valid;
    logic [CHAR_W-1:0]  em_data;
    logic               em_last;
    logic               em_ovf;
    logic               em_fire;
    logic               out_sep;

    gww_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign is_end    = (i_s_axis_tuser == CMD_END);
    assign is_sep    = (i_s_axis_tdata == CH_SPACE) || (i_s_axis_tdata == CH_TAB) ||
                       (i_s_axis_tdata == CH_NL);
    assign emit_ok   = !r_out_valid || i_m_axis_tready;
    assign last_byte = ((r_idx + LEN_W'(1)) == r_wl);
    assign em_fire   = em_valid && emit_ok;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (is_end) begin
                        if (r_wl != '0) begin
                            n_state = S_FIT;
                        end else if (r_ll != '0) begin
                            n_state = S_END_NL;
                        end
                    end else if (is_sep && (r_wl != '0)) begin
                        n_state = S_FIT;
                    end
                end
            end
            S_FIT: begin
                if ((r_ll != '0) && alu_rsp.gt) begin
                    n_state = S_NL;
                end else if (r_ll != '0) begin
                    n_state = S_SP;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_NL: begin
                if (emit_ok) n_state = S_ADD;
            end
            S_SP: begin
                if (emit_ok) n_state = S_ADD;
            end
            S_ADD: begin
                n_state = S_WORD;
            end
            S_WORD: begin
                if (emit_ok && last_byte) begin
                    n_state = (r_end && (r_ll != '0)) ? S_END_NL : S_IDLE;
                end
            end
            S_END_NL: begin
                if (emit_ok) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and emission
    always_comb begin
        n_ll          = r_ll;
        n_wl          = r_wl;
        n_idx         = r_idx;
        n_ovf         = r_ovf;
        alu_req.a     = r_ll;
        alu_req.b     = LINE_W'(r_wl);
        alu_req.cin   = 1'b1;
        alu_req.limit = r_width;
        em_valid      = 1'b0;
        em_data       = CH_NL;
        em_last       = 1'b0;
        em_ovf        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_idx = '0;
                    if (!is_end && !is_sep) begin
                        if (r_wl < LEN_W'(MAX_WORD)) begin
                            n_wl = r_wl + LEN_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
            S_FIT: begin
            end
            S_NL: begin
                em_valid = 1'b1;
                if (emit_ok) n_ll = '0;
            end
            S_SP: begin
                alu_req.b = '0;
                em_valid  = 1'b1;
                em_data   = CH_SPACE;
                if (emit_ok) n_ll = alu_rsp.sum[LINE_W-1:0];
            end
            S_ADD: begin
                alu_req.cin = 1'b0;
                n_ll        = alu_rsp.sum[LINE_W-1:0];
            end
            S_WORD: begin
                em_valid = 1'b1;
                em_data  = r_rd_data;
                em_ovf   = r_ovf;
                em_last  = last_byte && !(r_end && (r_ll != '0));
                if (emit_ok) begin
                    if (last_byte) begin
                        n_idx = '0;
                        n_wl  = '0;
                        n_ovf = 1'b0;
                    end else begin
                        n_idx = r_idx + LEN_W'(1);
                    end
                end
            end
            S_END_NL: begin
                em_valid = 1'b1;
                em_last  = 1'b1;
                if (emit_ok) n_ll = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= LINE_WIDTH_RST;
            r_ll        <= '0;
            r_wl        <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ll    <= n_ll;
            r_wl    <= n_wl;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            if (i_cfg_we) r_width <= i_cfg_wdata;
            if (acc) r_end <= is_end;
            if (em_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_fire) begin
            r_out_data <= em_data;
            r_out_last <= em_last;
            r_out_ovf  <= em_ovf;
        end
    end

    // word buffer: write on text byte below capacity, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (acc && !is_end && !is_sep && (r_wl < LEN_W'(MAX_WORD))) begin
            r_mem[r_wl[IDX_W-1:0]] <= i_s_axis_tdata;
        end
        r_rd_data <= r_mem[n_idx[IDX_W-1:0]];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_ovf;

    assign out_sep = (o_m_axis_tdata == CH_SPACE) || (o_m_axis_tdata == CH_NL);

    `GWW_ASSERT_NOW(a_idx_in_word, i_clk, i_rst_n, r_state == S_WORD, r_idx < r_wl)
    `GWW_ASSERT_NEXT(a_end_nl_clears, i_clk, i_rst_n, (r_state == S_END_NL) && emit_ok, r_ll == '0)
    `GWW_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, em_fire && em_last, r_state == S_IDLE)
    `GWW_ASSERT_NOW(a_ovf_word_only, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, !out_sep)

endmodule

// ===== bench/greedy_word_wrap_tb.sv =====
// Self-checking testbench for the greedy word-wrap line filler.
`timescale 1ns / 100ps

module greedy_word_wrap_tb;
    import gww_pkg::*;

    localparam int WORD_CAP = MAX_WORD_DEF;
    localparam int CFG_SETTLE = WORD_CAP + 8;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              ovf;
    } t_wrap_byte;

    class t_line_fill_checker;
        logic [LINE_W-1:0] line_width;
        logic [CHAR_W-1:0] word_buf [WORD_CAP];
        int unsigned       word_cnt;
        bit [LINE_W-1:0]   line_len;
        bit                ovf_seen;
        t_wrap_byte        expected_bytes [$];
        int                mismatches;

        function new();
            line_width = LINE_WIDTH_RST;
            word_cnt = 0;
            line_len = '0;
            ovf_seen = 1'b0;
            mismatches = 0;
        endfunction

        function void set_width(logic [LINE_W-1:0] w);
            line_width = w;
        endfunction

        function void push_byte(logic [CHAR_W-1:0] ch, logic flag);
            t_wrap_byte b;
            b.ch = ch;
            b.last = 1'b0;
            b.ovf = flag;
            expected_bytes.push_back(b);
        endfunction

        function void flush_word();
            if (word_cnt == 0)
                return;
            if (line_len > 0 && int'(line_len) + 1 + word_cnt > int'(line_width)) begin
                push_byte(CH_NL, 1'b0);
                line_len = '0;
            end
            if (line_len > 0) begin
                push_byte(CH_SPACE, 1'b0);
                line_len = line_len + LINE_W'(1);
            end
            for (int k = 0; k < word_cnt; k++)
                push_byte(word_buf[k], ovf_seen);
            line_len = line_len + word_cnt[LINE_W-1:0];
            word_cnt = 0;
            ovf_seen = 1'b0;
        endfunction

        function void note_text_item(logic cmd, logic [CHAR_W-1:0] ch);
            int before_cnt;
            t_wrap_byte tail;
            before_cnt = expected_bytes.size();
            if (cmd == CMD_END) begin
                flush_word();
                if (line_len > 0) begin
                    push_byte(CH_NL, 1'b0);
                    line_len = '0;
                end
            end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NL) begin
                flush_word();
            end else if (word_cnt < WORD_CAP) begin
                word_buf[word_cnt] = ch;
                word_cnt++;
            end else begin
                ovf_seen = 1'b1;
            end
            if (expected_bytes.size() > before_cnt) begin
                tail = expected_bytes.pop_back();
                tail.last = 1'b1;
                expected_bytes.push_back(tail);
            end
        endfunction

        function void check_out_byte(logic [CHAR_W-1:0] ch, logic last, logic ovf);
            t_wrap_byte exp_b;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output item: data %02h last %0b user %0b",
                             ch, last, ovf);
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (exp_b.ch !== ch || exp_b.last !== last || exp_b.ovf !== ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected data %02h last %0b user %0b, got %02h %0b %0b",
                             exp_b.ch, exp_b.last, exp_b.ovf, ch, last, ovf);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [LINE_W-1:0] i_cfg_wdata;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [CHAR_W-1:0] i_s_axis_tdata;
    logic              i_s_axis_tuser;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [CHAR_W-1:0] o_m_axis_tdata;
    logic              o_m_axis_tlast;
    logic              o_m_axis_tuser;

    t_line_fill_checker chk = new();
    bit idle_on;
    bit long_hold_req;

    greedy_word_wrap #(
        .MAX_WORD(WORD_CAP)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            chk.check_out_byte(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= cmd;
        i_s_axis_tdata <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        chk.note_text_item(cmd, ch);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_item(CMD_TEXT, s[i]);
    endtask

    task automatic wait_drain();
        while (chk.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_width(input logic [LINE_W-1:0] w);
        i_s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (CFG_SETTLE) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        chk.set_width(w);
    endtask

    function automatic logic [CHAR_W-1:0] pick_sep();
        case ($urandom_range(0, 2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    task automatic run_random(input int n_items);
        int sent;
        int kind;
        int len;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(WORD_CAP - 2, WORD_CAP + 8)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        ch = CHAR_W'($urandom_range(0, 255));
                        if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NL)
                            ch = ch ^ 8'h40;
                    end else begin
                        ch = CHAR_W'($urandom_range(8'h21, 8'h7E));
                    end
                    send_item(CMD_TEXT, ch);
                end
                send_item(CMD_TEXT, pick_sep());
                sent += len;
                if ($urandom_range(0, 4) == 0) begin
                    send_item(CMD_TEXT, pick_sep());
                    sent++;
                end
            end else if (kind < 85) begin
                send_item(CMD_TEXT, CHAR_W'($urandom_range(0, 255)));
            end else if (kind < 93) begin
                send_item(CMD_END, CHAR_W'($urandom_range(0, 255)));
            end else begin
                send_item(CMD_TEXT, pick_sep());
            end
            sent++;
        end
        send_item(CMD_END, CHAR_W'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = CMD_TEXT;
        i_m_axis_tready = 1'b0;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(CMD_TEXT, CH_SPACE);
        send_item(CMD_END, 8'h00);
        send_item(CMD_TEXT, "a");
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_TEXT, CH_TAB);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, 8'h7F);
        send_item(CMD_TEXT, CH_NL);
        send_item(CMD_TEXT, "b");
        send_item(CMD_END, 8'hFF);
        send_item(CMD_TEXT, "c");
        send_item(CMD_END, 8'h5A);

        set_width(10'd4);
        send_text("abcde");
        send_item(CMD_TEXT, CH_SPACE);
        send_text("fg");
        send_item(CMD_END, 8'h00);

        set_width(10'd1);
        run_random(24);
        set_width(10'd1023);
        run_random(24);
        set_width(LINE_WIDTH_RST);
        long_hold_req = 1'b1;
        run_random(24);
        set_width(LINE_W'($urandom_range(2, 40)));
        run_random(24);
        set_width(LINE_W'($urandom_range(1, 1023)));
        idle_on = 1'b0;
        run_random(24);

        i_s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (CFG_SETTLE) @(negedge i_clk);
        if (chk.mismatches == 0 && chk.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gww_pkg.sv
rtl/gww_alu.sv
rtl/greedy_word_wrap.sv
bench/greedy_word_wrap_tb.sv
